// ===== design/scad_pkg.sv =====
// ----------------------------------------------------------------------------
// scad_pkg
// Types, codes and constants shared by the sine/cosine angle decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scad_pkg;

	localparam int unsigned SAMPLE_BITS_DEF  = 16;
	localparam int unsigned SIN_CAP_LOW_DEF  = 0;
	localparam int unsigned SIN_CAP_HIGH_DEF = 65535;
	localparam int unsigned COS_CAP_LOW_DEF  = 0;
	localparam int unsigned COS_CAP_HIGH_DEF = 65535;

	localparam int unsigned CORDIC_STEPS = 24;
	localparam int unsigned DIV_STEPS    = 34;

	// register indexes
	localparam logic [2:0] REG_FIT_ENABLE   = 3'd0;
	localparam logic [2:0] REG_FIT_CENTERS  = 3'd1;
	localparam logic [2:0] REG_FIT_GAIN_SIN = 3'd2;
	localparam logic [2:0] REG_FIT_GAIN_COS = 3'd3;
	localparam logic [2:0] REG_FIT_PHASE    = 3'd4;
	localparam logic [2:0] REG_FB_SIN       = 3'd5;
	localparam logic [2:0] REG_FB_COS       = 3'd6;
	localparam logic [2:0] REG_MIN_SPAN     = 3'd7;

	typedef enum logic [1:0] {
		MODE_DECODE = 2'd0,
		MODE_CLEAR  = 2'd1,
		MODE_SEED   = 2'd2,
		MODE_NONE   = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_FIT,
		ST_DIV_S,
		ST_DIV_C,
		ST_CORD_INIT,
		ST_CORD,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic [1:0]  mode;
		logic [15:0] sine_sample;
		logic [15:0] cosine_sample;
	} in_item_t;

	typedef struct packed {
		logic [15:0] angle_turns;
		logic        learned_in_use;
		logic        fit_used;
		logic        angle_defined;
	} out_item_t;

	// atan(2^-i) in 2^-32 turns
	function automatic logic [31:0] atan_step(input logic [4:0] idx);
		logic [31:0] r;
		case (idx)
			5'd0:  r = 32'd536870912;
			5'd1:  r = 32'd316933406;
			5'd2:  r = 32'd167458907;
			5'd3:  r = 32'd85004756;
			5'd4:  r = 32'd42667331;
			5'd5:  r = 32'd21354465;
			5'd6:  r = 32'd10679838;
			5'd7:  r = 32'd5340245;
			5'd8:  r = 32'd2670163;
			5'd9:  r = 32'd1335087;
			5'd10: r = 32'd667544;
			5'd11: r = 32'd333772;
			5'd12: r = 32'd166886;
			5'd13: r = 32'd83443;
			5'd14: r = 32'd41722;
			5'd15: r = 32'd20861;
			5'd16: r = 32'd10430;
			5'd17: r = 32'd5215;
			5'd18: r = 32'd2608;
			5'd19: r = 32'd1304;
			5'd20: r = 32'd652;
			5'd21: r = 32'd326;
			5'd22: r = 32'd163;
			5'd23: r = 32'd81;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

	// 2*(v-lo) - (hi-lo), signed
	function automatic logic signed [18:0] norm_num(input logic [15:0] v,
			input logic [15:0] lo, input logic [15:0] hi);
		logic signed [18:0] d;
		logic signed [18:0] sp;
		d  = 19'(signed'({3'b000, v})) - 19'(signed'({3'b000, lo}));
		sp = 19'(signed'({3'b000, hi})) - 19'(signed'({3'b000, lo}));
		return (d <<< 1) - sp;
	endfunction

endpackage

`default_nettype wire

// ===== design/sincos_angle_decoder_top.sv =====
// ----------------------------------------------------------------------------
// sincos_angle_decoder_top
// Angle of an analog sine/cosine rotary sensor as a 16-bit fraction of a turn.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel in_valid / in_stall / in_item carries one item: a mode and
//    a raw sine and cosine sample. in_stall is high while an item is at work.
//  - Output channel out_valid / out_stall / out_item returns one result item
//    per input item. A result waits in the output register while out_stall is
//    high; the next input item is accepted meanwhile, and its result is held
//    back in the sequencer until the register frees.
//  - Configuration: cfg_we, cfg_index, cfg_data write one register a cycle.
//    Write only while the block is idle.
//  - Clear, seed and unused modes go from idle straight to the done state.
//    Fit decode uses the shared 35x17 multiplier for four products, then 24
//    CORDIC steps. Bounds decode runs two 34-step restoring divisions on one
//    shared subtractor, then 24 CORDIC steps. One item is in work at a time.
//  - Reset clears the sequencer, the output register, the learned bounds to
//    empty and the registers to their defaults; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module sincos_angle_decoder_top #(
	parameter int unsigned SAMPLE_BITS  = scad_pkg::SAMPLE_BITS_DEF,
	parameter int unsigned SIN_CAP_LOW  = scad_pkg::SIN_CAP_LOW_DEF,
	parameter int unsigned SIN_CAP_HIGH = scad_pkg::SIN_CAP_HIGH_DEF,
	parameter int unsigned COS_CAP_LOW  = scad_pkg::COS_CAP_LOW_DEF,
	parameter int unsigned COS_CAP_HIGH = scad_pkg::COS_CAP_HIGH_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire scad_pkg::in_item_t  in_item,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output scad_pkg::out_item_t      out_item,
	input  wire logic                cfg_we,
	input  wire logic [2:0]          cfg_index,
	input  wire logic [31:0]         cfg_data
);
	import scad_pkg::*;

	localparam logic [15:0] SMASK  = 16'((32'd1 << SAMPLE_BITS) - 32'd1);
	localparam logic [15:0] S_LO   = 16'(SIN_CAP_LOW);
	localparam logic [15:0] S_HI   = 16'(SIN_CAP_HIGH);
	localparam logic [15:0] C_LO   = 16'(COS_CAP_LOW);
	localparam logic [15:0] C_HI   = 16'(COS_CAP_HIGH);

	// configuration registers
	logic        fit_enable_q;
	logic [31:0] fit_centers_q, gain_sin_q, gain_cos_q, fit_phase_q;
	logic [31:0] fb_sin_q, fb_cos_q;
	logic [15:0] min_span_q;

	// learned bounds
	logic [15:0] seen_sin_lo_q, seen_sin_hi_q, seen_cos_lo_q, seen_cos_hi_q;

	state_t state_q, state_d;
	logic   in_acc, out_acc;

	logic [15:0] cs_q, cc_q;
	logic [15:0] cmin_q, cmax_q;
	logic [5:0]  cnt_q;
	logic        learned_q, fit_q, defined_q;

	// shared multiplier
	logic signed [34:0] mul_a;
	logic signed [16:0] mul_b;
	logic signed [51:0] prod_q;
	logic signed [16:0] ds_q, dc_q;
	logic signed [32:0] s_q, c0_q;
	logic signed [34:0] t_q;

	// shared divider
	logic [15:0] span_q, rem_q;
	logic [33:0] dvd_q;
	logic        neg_q;
	logic [16:0] rem_sh;
	logic        rem_ge;
	logic [33:0] quo_next;
	logic signed [39:0] quo_signed;

	// CORDIC
	logic signed [39:0] x_q, y_q, dx, dy;
	logic [31:0] acc_q;

	// output register
	logic        out_valid_q;
	out_item_t   out_q;

	// clamp: low cap first, then high cap
	logic [15:0] s_m, c_m, s_c1, c_c1, cs_in, cc_in;
	logic learned_now;
	logic signed [18:0] num_s, num_c;

	always_comb begin
		s_m   = in_item.sine_sample & SMASK;
		c_m   = in_item.cosine_sample & SMASK;
		s_c1  = (s_m < S_LO) ? S_LO : s_m;
		cs_in = (s_c1 > S_HI) ? S_HI : s_c1;
		c_c1  = (c_m < C_LO) ? C_LO : c_m;
		cc_in = (c_c1 > C_HI) ? C_HI : c_c1;
	end

	assign in_acc   = in_valid && (state_q == ST_IDLE);
	assign in_stall = (state_q != ST_IDLE);
	assign out_acc  = out_valid_q && !out_stall;

	// learned test on the already widened bounds, no wrap
	assign learned_now =
		({1'b0, seen_sin_hi_q} >= ({1'b0, seen_sin_lo_q} + {1'b0, min_span_q})) &&
		({1'b0, seen_cos_hi_q} >= ({1'b0, seen_cos_lo_q} + {1'b0, min_span_q}));

	assign num_s = norm_num(cs_q, learned_now ? seen_sin_lo_q : fb_sin_q[15:0],
		learned_now ? seen_sin_hi_q : fb_sin_q[31:16]);
	assign num_c = norm_num(cc_q, cmin_q, cmax_q);

	// multiplier operand select by step
	always_comb begin
		case (cnt_q)
			6'd1: begin
				mul_a = 35'(signed'({1'b0, gain_cos_q}));
				mul_b = dc_q;
			end
			6'd2: begin
				mul_a = 35'(s_q);
				mul_b = 17'(signed'(fit_phase_q[15:0]));
			end
			6'd4: begin
				mul_a = t_q;
				mul_b = signed'({1'b0, fit_phase_q[31:16]});
			end
			default: begin
				mul_a = 35'(signed'({1'b0, gain_sin_q}));
				mul_b = ds_q;
			end
		endcase
	end

	// divider step
	always_comb begin
		rem_sh     = {rem_q, dvd_q[33]};
		rem_ge     = rem_sh >= {1'b0, span_q};
		quo_next   = {dvd_q[32:0], rem_ge};
		quo_signed = neg_q ? -40'(signed'({1'b0, quo_next}))
			: 40'(signed'({1'b0, quo_next}));
	end

	assign dx = x_q >>> cnt_q[4:0];
	assign dy = y_q >>> cnt_q[4:0];

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = (mode_t'(in_item.mode) == MODE_DECODE) ? ST_PREP : ST_DONE;
				end
			end
			ST_PREP: begin
				if (fit_enable_q) begin
					state_d = ST_FIT;
				end else if ((learned_now ? (seen_sin_hi_q > seen_sin_lo_q &&
						seen_cos_hi_q > seen_cos_lo_q) :
						(fb_sin_q[31:16] > fb_sin_q[15:0] &&
						fb_cos_q[31:16] > fb_cos_q[15:0]))) begin
					state_d = ST_DIV_S;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_FIT:   if (cnt_q == 6'd5) state_d = ST_CORD_INIT;
			ST_DIV_S: if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_DIV_C;
			ST_DIV_C: if (cnt_q == 6'(DIV_STEPS - 1)) state_d = ST_CORD_INIT;
			ST_CORD_INIT: begin
				state_d = (x_q == '0 && y_q == '0) ? ST_DONE : ST_CORD;
			end
			ST_CORD:  if (cnt_q == 6'(CORDIC_STEPS - 1)) state_d = ST_DONE;
			ST_DONE:  if (!out_valid_q || !out_stall) state_d = ST_IDLE;
			default:  state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration and learned bounds
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fit_enable_q  <= 1'b0;
			fit_centers_q <= 32'd2147516416;
			gain_sin_q    <= '0;
			gain_cos_q    <= '0;
			fit_phase_q   <= 32'd1073741824;
			fb_sin_q      <= 32'hFFFF0000;
			fb_cos_q      <= 32'hFFFF0000;
			min_span_q    <= 16'd1024;
			seen_sin_lo_q <= 16'hFFFF;
			seen_sin_hi_q <= '0;
			seen_cos_lo_q <= 16'hFFFF;
			seen_cos_hi_q <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FIT_ENABLE:   fit_enable_q  <= cfg_data[0];
					REG_FIT_CENTERS:  fit_centers_q <= cfg_data;
					REG_FIT_GAIN_SIN: gain_sin_q    <= cfg_data;
					REG_FIT_GAIN_COS: gain_cos_q    <= cfg_data;
					REG_FIT_PHASE:    fit_phase_q   <= cfg_data;
					REG_FB_SIN:       fb_sin_q      <= cfg_data;
					REG_FB_COS:       fb_cos_q      <= cfg_data;
					REG_MIN_SPAN:     min_span_q    <= cfg_data[15:0];
					default: ;
				endcase
			end
			if (in_acc) begin
				case (mode_t'(in_item.mode))
					MODE_CLEAR: begin
						seen_sin_lo_q <= 16'hFFFF;
						seen_sin_hi_q <= '0;
						seen_cos_lo_q <= 16'hFFFF;
						seen_cos_hi_q <= '0;
					end
					MODE_SEED: begin
						seen_sin_lo_q <= fb_sin_q[15:0];
						seen_sin_hi_q <= fb_sin_q[31:16];
						seen_cos_lo_q <= fb_cos_q[15:0];
						seen_cos_hi_q <= fb_cos_q[31:16];
					end
					MODE_DECODE: begin
						// widen the learned bounds
						if (cs_in < seen_sin_lo_q) seen_sin_lo_q <= cs_in;
						if (cs_in > seen_sin_hi_q) seen_sin_hi_q <= cs_in;
						if (cc_in < seen_cos_lo_q) seen_cos_lo_q <= cc_in;
						if (cc_in > seen_cos_hi_q) seen_cos_hi_q <= cc_in;
					end
					default: ;
				endcase
			end
		end
	end

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			learned_q <= 1'b0;
			fit_q     <= 1'b0;
			defined_q <= 1'b0;
			cnt_q     <= '0;
		end else begin
			prod_q <= mul_a * mul_b;
			case (state_q)
				ST_IDLE: begin
					cs_q      <= cs_in;
					cc_q      <= cc_in;
					learned_q <= 1'b0;
					fit_q     <= 1'b0;
					defined_q <= 1'b0;
					acc_q     <= '0;
					cnt_q     <= '0;
				end
				ST_PREP: begin
					learned_q <= learned_now;
					fit_q     <= fit_enable_q;
					defined_q <= (state_d != ST_DONE);
					cmin_q    <= learned_now ? seen_cos_lo_q : fb_cos_q[15:0];
					cmax_q    <= learned_now ? seen_cos_hi_q : fb_cos_q[31:16];
					ds_q      <= signed'({1'b0, cs_q}) - signed'({1'b0, fit_centers_q[15:0]});
					dc_q      <= signed'({1'b0, cc_q}) - signed'({1'b0, fit_centers_q[31:16]});
					span_q    <= learned_now ? (seen_sin_hi_q - seen_sin_lo_q)
						: (fb_sin_q[31:16] - fb_sin_q[15:0]);
					neg_q     <= num_s[18];
					dvd_q     <= {(num_s[18] ? 18'(-num_s) : 18'(num_s)), 16'd0};
					rem_q     <= '0;
					cnt_q     <= '0;
				end
				ST_FIT: begin
					// one multiply per step, each result registered
					case (cnt_q)
						6'd1: s_q  <= prod_q[48:16];
						6'd2: c0_q <= prod_q[48:16];
						6'd3: t_q  <= 35'(c0_q) + 35'(signed'(prod_q[48:15]));
						6'd5: begin
							x_q <= 40'(signed'(prod_q[50:14]));
							y_q <= 40'(s_q);
						end
						default: ;
					endcase
					cnt_q <= (cnt_q == 6'd5) ? '0 : cnt_q + 6'd1;
				end
				ST_DIV_S, ST_DIV_C: begin
					if (cnt_q == 6'(DIV_STEPS - 1)) begin
						cnt_q <= '0;
						if (state_q == ST_DIV_S) begin
							y_q    <= quo_signed;
							span_q <= cmax_q - cmin_q;
							neg_q  <= num_c[18];
							dvd_q  <= {(num_c[18] ? 18'(-num_c) : 18'(num_c)), 16'd0};
							rem_q  <= '0;
						end else begin
							x_q <= quo_signed;
						end
					end else begin
						rem_q <= rem_ge ? 16'(rem_sh - {1'b0, span_q}) : rem_sh[15:0];
						dvd_q <= quo_next;
						cnt_q <= cnt_q + 6'd1;
					end
				end
				ST_CORD_INIT: begin
					cnt_q <= '0;
					if (x_q < 0) begin
						x_q   <= -x_q;
						y_q   <= -y_q;
						acc_q <= 32'h8000_0000;
					end
				end
				ST_CORD: begin
					if (!y_q[39]) begin
						x_q   <= x_q + dy;
						y_q   <= y_q - dx;
						acc_q <= acc_q + atan_step(cnt_q[4:0]);
					end else begin
						x_q   <= x_q - dy;
						y_q   <= y_q + dx;
						acc_q <= acc_q - atan_step(cnt_q[4:0]);
					end
					cnt_q <= cnt_q + 6'd1;
				end
				default: ;
			endcase
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_acc) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_DONE && (!out_valid_q || !out_stall)) begin
			out_q.angle_turns    <= 16'((acc_q + 32'h8000) >> 16);
			out_q.learned_in_use <= learned_q;
			out_q.fit_used       <= fit_q;
			out_q.angle_defined  <= defined_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// an undefined angle is always zero
	a_undef_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.angle_defined |-> out_q.angle_turns == 16'd0)
		else $error("undefined angle not zero");

	// the fit path always defines the angle
	a_fit_defined: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.fit_used |-> out_q.angle_defined)
		else $error("fit result without defined angle");

	// a clear item empties the learned bounds
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && mode_t'(in_item.mode) == MODE_CLEAR |=>
		seen_sin_lo_q == 16'hFFFF && seen_cos_hi_q == 16'd0)
		else $error("learned bounds not cleared");

	// the CORDIC counter stays within its step table
	a_cord_cnt: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_CORD |-> cnt_q < 6'(CORDIC_STEPS))
		else $error("CORDIC step out of range");

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the sine/cosine angle decoder: a clocked driver
// feeds items from a queue, a clocked monitor checks every result against a
// bit-exact fixed-point predictor, across several register settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
	import scad_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	in_item_t    in_item = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	out_item_t   out_item;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = REG_FIT_ENABLE;
	logic [31:0] cfg_data = '0;

	// predictor copy of registers and learned bounds
	logic        p_fit_en;
	logic [31:0] p_centers, p_gain_s, p_gain_c, p_phase, p_fb_s, p_fb_c;
	logic [15:0] p_min_span;
	logic [15:0] lrn_s_lo, lrn_s_hi, lrn_c_lo, lrn_c_hi;

	in_item_t  pending_items[$];
	out_item_t expected_angles[$];

	int  send_idle_pct = 0;
	int  recv_idle_pct = 0;
	int  recv_hold = 0;     // cycles the receiver is forced to stall
	bit  failed = 1'b0;
	int  quiet_cycles = 0;

	always #2 clk = ~clk;

	sincos_angle_decoder_top u_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
		.out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	function automatic logic signed [63:0] asr64(input logic signed [63:0] v, input int k);
		return v >>> k;
	endfunction

	// fixed CORDIC vectoring, angle in 2^-16 turns
	function automatic logic [15:0] cordic_angle(input logic signed [63:0] y0,
			input logic signed [63:0] x0);
		logic signed [63:0] x, y, dx, dy;
		logic [31:0] acc;
		x = x0; y = y0; acc = 0;
		if (x == 0 && y == 0) return 16'd0;
		if (x < 0) begin
			x = -x; y = -y; acc = 32'h8000_0000;
		end
		for (int i = 0; i < CORDIC_STEPS; i++) begin
			dx = x >>> i;
			dy = y >>> i;
			if (y >= 0) begin
				x += dy; y -= dx; acc += atan_turns(i);
			end else begin
				x -= dy; y += dx; acc -= atan_turns(i);
			end
		end
		acc = acc + 32'h8000;
		return acc[31:16];
	endfunction

	function automatic logic [31:0] atan_turns(input int i);
		logic [31:0] t[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
			21354465, 10679838, 5340245, 2670163, 1335087, 667544, 333772, 166886,
			83443, 41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};
		return t[i];
	endfunction

	function automatic logic signed [63:0] span_scale(input logic [15:0] v,
			input logic [15:0] lo, input logic [15:0] hi);
		logic signed [63:0] sp, num;
		sp = $signed({48'd0, hi}) - $signed({48'd0, lo});
		num = (2 * ($signed({48'd0, v}) - $signed({48'd0, lo})) - sp) * 65536;
		return num / sp;   // truncates toward zero
	endfunction

	// advance the predictor by one item
	task automatic predict_angle(input in_item_t it);
		out_item_t r;
		logic [15:0] s, c, smin, smax, cmin, cmax;
		logic signed [63:0] ds, dc, sv, cv;
		logic learned;
		r = '0;
		case (mode_t'(it.mode))
			MODE_CLEAR: begin
				lrn_s_lo = 16'hFFFF; lrn_s_hi = 0; lrn_c_lo = 16'hFFFF; lrn_c_hi = 0;
			end
			MODE_SEED: begin
				lrn_s_lo = p_fb_s[15:0]; lrn_s_hi = p_fb_s[31:16];
				lrn_c_lo = p_fb_c[15:0]; lrn_c_hi = p_fb_c[31:16];
			end
			MODE_DECODE: begin
				s = it.sine_sample; c = it.cosine_sample;
				if (s < lrn_s_lo) lrn_s_lo = s;
				if (s > lrn_s_hi) lrn_s_hi = s;
				if (c < lrn_c_lo) lrn_c_lo = c;
				if (c > lrn_c_hi) lrn_c_hi = c;
				learned = ({1'b0, lrn_s_hi} >= {1'b0, lrn_s_lo} + p_min_span) &&
					({1'b0, lrn_c_hi} >= {1'b0, lrn_c_lo} + p_min_span);
				if (learned) begin
					smin = lrn_s_lo; smax = lrn_s_hi; cmin = lrn_c_lo; cmax = lrn_c_hi;
				end else begin
					smin = p_fb_s[15:0]; smax = p_fb_s[31:16];
					cmin = p_fb_c[15:0]; cmax = p_fb_c[31:16];
				end
				r.learned_in_use = learned;
				if (p_fit_en) begin
					ds = $signed({48'd0, s}) - $signed({48'd0, p_centers[15:0]});
					dc = $signed({48'd0, c}) - $signed({48'd0, p_centers[31:16]});
					sv = asr64(ds * $signed({32'd0, p_gain_s}), 16);
					cv = asr64(dc * $signed({32'd0, p_gain_c}), 16);
					cv = cv + asr64(sv * 64'(signed'(p_phase[15:0])), 15);
					cv = asr64(cv * $signed({48'd0, p_phase[31:16]}), 14);
					r.angle_turns = cordic_angle(sv, cv);
					r.fit_used = 1'b1;
					r.angle_defined = 1'b1;
				end else if (smax > smin && cmax > cmin) begin
					r.angle_turns = cordic_angle(span_scale(s, smin, smax),
						span_scale(c, cmin, cmax));
					r.angle_defined = 1'b1;
				end
			end
			default: ;
		endcase
		expected_angles.push_back(r);
	endtask

	// driver: offer the head of the queue, drop it once accepted
	always @(posedge clk) begin
		if (in_valid && !in_stall) begin
			predict_angle(pending_items.pop_front());
		end
		if (arst_n && pending_items.size() > 0
				&& (in_valid && in_stall || $urandom_range(99) >= send_idle_pct)) begin
			in_valid <= 1'b1;
			in_item  <= pending_items[0];
		end else if (!(in_valid && in_stall)) begin
			in_valid <= 1'b0;
		end
	end

	// monitor: compare each accepted result with the oldest expectation
	always @(posedge clk) begin
		out_item_t e;
		if (out_valid && !out_stall) begin
			if (expected_angles.size() == 0) begin
				$error("result with nothing expected: %h", out_item);
				failed = 1'b1;
			end else begin
				e = expected_angles.pop_front();
				if (out_item.angle_turns !== e.angle_turns) begin
					$error("angle_turns exp %h got %h", e.angle_turns, out_item.angle_turns);
					failed = 1'b1;
				end
				if (out_item.learned_in_use !== e.learned_in_use) begin
					$error("learned_in_use exp %b got %b", e.learned_in_use,
						out_item.learned_in_use);
					failed = 1'b1;
				end
				if (out_item.fit_used !== e.fit_used) begin
					$error("fit_used exp %b got %b", e.fit_used, out_item.fit_used);
					failed = 1'b1;
				end
				if (out_item.angle_defined !== e.angle_defined) begin
					$error("angle_defined exp %b got %b", e.angle_defined,
						out_item.angle_defined);
					failed = 1'b1;
				end
			end
		end
		// receiver stall: count down a long hold first, else random
		if (recv_hold > 0) begin
			recv_hold <= recv_hold - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// watchdog on cycles with no accepted item
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall)
				|| (pending_items.size() == 0 && expected_angles.size() == 0)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			REG_FIT_ENABLE:   p_fit_en   = val[0];
			REG_FIT_CENTERS:  p_centers  = val;
			REG_FIT_GAIN_SIN: p_gain_s   = val;
			REG_FIT_GAIN_COS: p_gain_c   = val;
			REG_FIT_PHASE:    p_phase    = val;
			REG_FB_SIN:       p_fb_s     = val;
			REG_FB_COS:       p_fb_c     = val;
			REG_MIN_SPAN:     p_min_span = val[15:0];
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	// wait for the block to drain, then let a decode's worth of cycles pass
	task automatic drain();
		wait (pending_items.size() == 0 && !in_valid && expected_angles.size() == 0);
		repeat (150) @(posedge clk);
	endtask

	task automatic add_item(input mode_t m, input logic [15:0] s, input logic [15:0] c);
		in_item_t it;
		it.mode = m; it.sine_sample = s; it.cosine_sample = c;
		pending_items.push_back(it);
	endtask

	// random item: mostly decodes, many near mid-scale, some clear, seed and unused items
	task automatic add_random(input int n);
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(99);
			if (k < 3) add_item(MODE_CLEAR, $urandom, $urandom);
			else if (k < 6) add_item(MODE_SEED, $urandom, $urandom);
			else if (k < 8) add_item(MODE_NONE, $urandom, $urandom);
			else if (k < 40) add_item(MODE_DECODE, $urandom, $urandom);
			else add_item(MODE_DECODE, 16'd32768 + 16'($urandom_range(24000)) - 16'd12000,
				16'd32768 + 16'($urandom_range(24000)) - 16'd12000);
		end
	endtask

	task automatic random_setting(input bit fit);
		logic [15:0] a, b;
		write_reg(REG_FIT_ENABLE, {31'd0, fit});
		write_reg(REG_FIT_CENTERS, $urandom_range(1) ? 32'h8000_8000 : $urandom);
		write_reg(REG_FIT_GAIN_SIN, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000));
		write_reg(REG_FIT_GAIN_COS, $urandom_range(3) == 0 ? $urandom : $urandom_range(32'h40000));
		write_reg(REG_FIT_PHASE, {16'($urandom_range(32767)), 16'($urandom)});
		a = $urandom; b = $urandom;
		write_reg(REG_FB_SIN, $urandom_range(4) == 0 ? {a, b} : {16'hF000, 16'h1000});
		a = $urandom; b = $urandom;
		write_reg(REG_FB_COS, $urandom_range(4) == 0 ? {a, b} : {16'hF000, 16'h1000});
		write_reg(REG_MIN_SPAN, $urandom_range(3) == 0 ? $urandom : $urandom_range(4096));
	endtask

	initial begin
		p_fit_en = 0; p_centers = 32'd2147516416; p_gain_s = 0; p_gain_c = 0;
		p_phase = 32'd1073741824; p_fb_s = 32'hFFFF0000; p_fb_c = 32'hFFFF0000;
		p_min_span = 16'd1024;
		lrn_s_lo = 16'hFFFF; lrn_s_hi = 0; lrn_c_lo = 16'hFFFF; lrn_c_hi = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: defaults, extremes, empty spans, every mode
		add_item(MODE_DECODE, 16'd0, 16'd0);
		add_item(MODE_DECODE, 16'hFFFF, 16'hFFFF);
		add_item(MODE_DECODE, 16'h7FFF, 16'h8000);
		add_item(MODE_NONE, 16'hFFFF, 16'hFFFF);
		add_item(MODE_SEED, 16'd0, 16'd0);
		add_item(MODE_DECODE, 16'h5555, 16'hAAAA);
		add_item(MODE_CLEAR, 16'hFFFF, 16'hFFFF);
		add_item(MODE_DECODE, 16'h8000, 16'h8000);
		drain();
		write_reg(REG_FB_SIN, 32'h0000_FFFF);   // crossed: empty span
		write_reg(REG_FB_COS, 32'hC000_4000);
		write_reg(REG_MIN_SPAN, 16'hFFFF);
		add_item(MODE_SEED, 0, 0);
		add_item(MODE_DECODE, 16'h1234, 16'h4321);
		add_item(MODE_DECODE, 16'hFFFF, 16'h0000);
		drain();
		write_reg(REG_FIT_ENABLE, 32'd1);        // fit with zero gains
		add_item(MODE_DECODE, 16'hFFFF, 16'h0000);
		drain();
		write_reg(REG_FIT_GAIN_SIN, 32'hFFFF_FFFF);
		write_reg(REG_FIT_GAIN_COS, 32'hFFFF_FFFF);
		write_reg(REG_FIT_PHASE, 32'hFFFF_8000);
		write_reg(REG_FIT_CENTERS, 32'hFFFF_0000);
		write_reg(REG_MIN_SPAN, 32'd0);
		add_item(MODE_DECODE, 16'h0000, 16'hFFFF);
		add_item(MODE_DECODE, 16'hFFFF, 16'h0000);
		add_item(MODE_DECODE, 16'h8000, 16'h8000);
		drain();

		// random phases with varying idling and settings
		for (int ph = 0; ph < 6; ph++) begin
			send_idle_pct = (ph < 2) ? 21 : (ph < 4) ? 74 : 0;
			recv_idle_pct = (ph < 2) ? 74 : (ph < 4) ? 21 : 0;
			random_setting(ph[0]);
			if (ph == 4) recv_hold = 600;   // long hold-off: block fills and stalls
			add_random(250);
			if (ph == 2) begin
				wait (expected_angles.size() == 0 && pending_items.size() == 0);
				add_random(10);
			end
			drain();
		end
		send_idle_pct = 0; recv_idle_pct = 0;
		drain();

		if (!failed) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end
endmodule

`default_nettype wire

// ===== sim.f =====
design/scad_pkg.sv
design/sincos_angle_decoder_top.sv
dv/tb.sv
